// ===== rtl/core/i4nku_pkg.sv =====
// shared types and constants for the int4 neuron k-step update block
// no dependencies

package i4nku_pkg;

    localparam int NIB_W      = 4;
    localparam int NIB_N      = 16;
    localparam int ROW_W      = NIB_W * NIB_N;
    localparam int ROW_IDX_W  = $clog2(NIB_N);
    localparam int STEP_BITS  = 32;
    localparam int STEP_IDX_W = $clog2(STEP_BITS);
    localparam int THR_W      = 8;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRE_THRESHOLD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_COUNT     = CFG_IDX_W'(1);

    localparam logic [THR_W-1:0]     THR_RESET  = THR_W'(16);
    localparam logic [STEP_BITS-1:0] STEP_RESET = STEP_BITS'(1);
    localparam logic [NIB_W-1:0]     NIB_MAX    = {NIB_W{1'b1}};

    typedef struct packed {
        logic [7:0] potentials_in;
        logic [7:0] drives_in;
        logic       last_pair;
    } in_item_t;

    typedef struct packed {
        logic [7:0] potentials_out;
        logic       last_out;
    } out_item_t;

    typedef struct packed {
        logic                 built;
        logic                 wr_en;
        logic [ROW_IDX_W-1:0] wr_row;
        logic [ROW_W-1:0]     wr_data;
    } tbl_ctl_t;

    typedef enum logic [1:0] {
        BLD_INIT,
        BLD_STEP,
        BLD_WRITE,
        BLD_READY
    } bld_state_t;

endpackage

// ===== rtl/core/i4nku_table_build.sv =====
// k-step table builder: config registers and repeated squaring of the one-step map
// depends on i4nku_pkg

module i4nku_table_build
    import i4nku_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output tbl_ctl_t              ctl
);

    bld_state_t              state_reg, state_next;
    logic [ROW_IDX_W-1:0]    drive_reg, drive_next;
    logic [STEP_IDX_W-1:0]   bit_reg, bit_next;
    logic [THR_W-1:0]        thr_reg;
    logic [STEP_BITS-1:0]    step_reg;
    logic [ROW_W-1:0]        cur_reg, cur_next;
    logic [ROW_W-1:0]        acc_reg, acc_next;
    logic                    cfg_hit;

    function automatic logic [NIB_W-1:0] one_step(
        input logic [NIB_W-1:0] pot,
        input logic [NIB_W-1:0] drv,
        input logic [THR_W-1:0] thr
    );
        logic [NIB_W:0]   sum;
        logic [NIB_W-1:0] sat;
        sum = {1'b0, pot} + {1'b0, drv};
        sat = sum[NIB_W] ? NIB_MAX : sum[NIB_W-1:0];
        if (THR_W'(sat) >= thr)
        begin
            sat = '0;
        end
        return sat;
    endfunction

    function automatic logic [NIB_W-1:0] nib_sel(
        input logic [ROW_W-1:0] vec,
        input logic [NIB_W-1:0] idx
    );
        return vec[idx*NIB_W +: NIB_W];
    endfunction

    // config register decode
    always_comb
    begin
        unique case (cfg_index)
            CFG_FIRE_THRESHOLD: cfg_hit = cfg_we;
            CFG_STEP_COUNT:     cfg_hit = cfg_we;
            default:            cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= THR_RESET;
            step_reg <= STEP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FIRE_THRESHOLD: thr_reg  <= cfg_data[THR_W-1:0];
                CFG_STEP_COUNT:     step_reg <= cfg_data[STEP_BITS-1:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BLD_INIT;
            drive_reg <= '0;
            bit_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            drive_reg <= drive_next;
            bit_reg   <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        acc_reg <= acc_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        drive_next  = drive_reg;
        bit_next    = bit_reg;
        cur_next    = cur_reg;
        acc_next    = acc_reg;
        ctl.built   = (state_reg == BLD_READY);
        ctl.wr_en   = 1'b0;
        ctl.wr_row  = drive_reg;
        ctl.wr_data = acc_reg;

        unique case (state_reg)
            BLD_INIT:
            begin
                for (int x = 0; x < NIB_N; x++)
                begin
                    cur_next[x*NIB_W +: NIB_W] = one_step(NIB_W'(x), drive_reg, thr_reg);
                    acc_next[x*NIB_W +: NIB_W] = NIB_W'(x);
                end
                bit_next   = '0;
                state_next = BLD_STEP;
            end
            BLD_STEP:
            begin
                // acc = cur o acc when this count bit is set, cur = cur o cur
                for (int x = 0; x < NIB_N; x++)
                begin
                    if (step_reg[bit_reg])
                    begin
                        acc_next[x*NIB_W +: NIB_W] =
                            nib_sel(cur_reg, acc_reg[x*NIB_W +: NIB_W]);
                    end
                    cur_next[x*NIB_W +: NIB_W] = nib_sel(cur_reg, cur_reg[x*NIB_W +: NIB_W]);
                end
                if (bit_reg == STEP_IDX_W'(STEP_BITS - 1))
                begin
                    state_next = BLD_WRITE;
                end
                else
                begin
                    bit_next = bit_reg + 1'b1;
                end
            end
            BLD_WRITE:
            begin
                ctl.wr_en = 1'b1;
                if (drive_reg == ROW_IDX_W'(NIB_N - 1))
                begin
                    state_next = BLD_READY;
                end
                else
                begin
                    drive_next = drive_reg + 1'b1;
                    state_next = BLD_INIT;
                end
            end
            BLD_READY:
            begin
                state_next = BLD_READY;
            end
            default:
            begin
                state_next = BLD_INIT;
            end
        endcase

        // a write to the fire threshold or step count register restarts the build from the first drive row
        if (cfg_hit)
        begin
            state_next = BLD_INIT;
            drive_next = '0;
        end
    end

endmodule

// ===== rtl/core/int4_neuron_k_step_update.sv =====
// top level: k-step table memory and three-stage lookup pipeline
// depends on i4nku_pkg and i4nku_table_build
//
//  port group   direction  handshake            payload
//  in           input      in_valid / in_ready  in_data (in_item_t)
//  out          output     out_valid/out_ready  out_data (out_item_t)
//  cfg          input      cfg_we               cfg_index, cfg_data
//
// one transaction per cycle while the table is built and out_ready stays high; a transaction
// passes the input register, the two-port table read register and the output register
// after reset and after each write to the threshold or step count register the table is
// rebuilt, one row per drive value (16 rows), with in_ready low
// stalls on out_ready fill the stages back to the input, bubbles are squeezed out

module int4_neuron_k_step_update
    import i4nku_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    tbl_ctl_t         ctl;
    logic [ROW_W-1:0] tbl_mem [NIB_N];

    logic             a_valid_reg;
    in_item_t         a_data_reg;
    logic             b_valid_reg;
    logic [ROW_W-1:0] b_row_lo_reg;
    logic [ROW_W-1:0] b_row_hi_reg;
    logic [NIB_W-1:0] b_pot_lo_reg;
    logic [NIB_W-1:0] b_pot_hi_reg;
    logic             b_last_reg;
    logic             c_valid_reg;
    out_item_t        c_data_reg;
    out_item_t        c_data_next;
    logic             en_a;
    logic             en_b;
    logic             en_c;

    i4nku_table_build u_build (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ctl       (ctl)
    );

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            tbl_mem[ctl.wr_row] <= ctl.wr_data;
        end
    end

    assign en_c     = !c_valid_reg || out_ready;
    assign en_b     = !b_valid_reg || en_c;
    assign en_a     = !a_valid_reg || en_b;
    assign in_ready = ctl.built && en_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (en_a)
            begin
                a_valid_reg <= in_valid && in_ready;
            end
            if (en_b)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (en_c)
            begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    // stage a: input register
    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            a_data_reg <= in_data;
        end
    end

    // stage b: two row reads, indexed by drive
    always_ff @(posedge clk)
    begin
        if (en_b)
        begin
            b_row_lo_reg <= tbl_mem[a_data_reg.drives_in[3:0]];
            b_row_hi_reg <= tbl_mem[a_data_reg.drives_in[7:4]];
            b_pot_lo_reg <= a_data_reg.potentials_in[3:0];
            b_pot_hi_reg <= a_data_reg.potentials_in[7:4];
            b_last_reg   <= a_data_reg.last_pair;
        end
    end

    // stage c: nibble select by potential
    always_comb
    begin
        c_data_next.potentials_out = {b_row_hi_reg[b_pot_hi_reg*NIB_W +: NIB_W],
                                      b_row_lo_reg[b_pot_lo_reg*NIB_W +: NIB_W]};
        c_data_next.last_out       = b_last_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en_c)
        begin
            c_data_reg <= c_data_next;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_data  = c_data_reg;

endmodule

// ===== rtl/core/i4nku_checker.sv =====
// port-level checks for int4_neuron_k_step_update, bound to the top level
// depends on i4nku_pkg

module i4nku_checker
    import i4nku_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input in_item_t              in_data,
    input logic                  out_valid,
    input logic                  out_ready,
    input out_item_t             out_data,
    input logic                  cfg_we,
    input logic [CFG_IDX_W-1:0]  cfg_index
);

    logic cfg_hit;

    assign cfg_hit = cfg_we && (cfg_index == CFG_FIRE_THRESHOLD || cfg_index == CFG_STEP_COUNT);

    // register write starts a table rebuild that blocks input
    a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_hit |=> !in_ready ##1 !in_ready ##1 !in_ready)
        else $error("input accepted during table rebuild");

    // a fresh output comes from an accepted input, via stages a, b and c
    a_out_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 3))
        else $error("output transaction without matching input");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled output transaction changed");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_data))
        else $error("waiting input transaction changed");

endmodule

bind int4_neuron_k_step_update i4nku_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index)
);

// ===== tb/int4_neuron_k_step_update_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for int4_neuron_k_step_update: random and directed neuron pairs
// checked against an in-bench k-step table predictor, under several register settings
// depends on i4nku_pkg and the int4_neuron_k_step_update rtl

module int4_neuron_k_step_update_tb;
    import i4nku_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 10;
    localparam int DRAIN_CYCLES   = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(3);

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    in_item_t              in_data;
    logic                  out_valid;
    logic                  out_ready;
    out_item_t             out_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    in_item_t  pairs_to_send[$];
    out_item_t expected_pairs[$];

    logic [THR_W-1:0]     thr_reg;
    logic [STEP_BITS-1:0] steps_reg;
    logic [NIB_W-1:0]     kstep_tbl[256];
    bit                   tbl_ready;

    int  errors;
    int  send_gap;
    int  stall_left;
    int  idle_cycles;
    bit  send_burst;
    bit  recv_burst;

    int4_neuron_k_step_update dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [NIB_W-1:0] advance_once(logic [NIB_W-1:0] pot,
                                                      logic [NIB_W-1:0] drv);
        logic [NIB_W:0] sum;
        sum = {1'b0, pot} + {1'b0, drv};
        if (sum > {1'b0, NIB_MAX})
            sum = {1'b0, NIB_MAX};
        if ({{(THR_W-NIB_W-1){1'b0}}, sum} >= thr_reg)
            sum = '0;
        return sum[NIB_W-1:0];
    endfunction

    // k-step map per drive value by repeated squaring of the one-step map
    task automatic rebuild_kstep();
        logic [NIB_W-1:0] cur[16];
        logic [NIB_W-1:0] acc[16];
        logic [NIB_W-1:0] nxt[16];
        int d;
        int x;
        int b;
        for (d = 0; d < 16; d++)
        begin
            for (x = 0; x < 16; x++)
            begin
                cur[x[NIB_W-1:0]] = advance_once(x[NIB_W-1:0], d[NIB_W-1:0]);
                acc[x[NIB_W-1:0]] = x[NIB_W-1:0];
            end
            for (b = 0; b < STEP_BITS; b++)
            begin
                if (steps_reg[b])
                    for (x = 0; x < 16; x++)
                        acc[x[NIB_W-1:0]] = cur[acc[x[NIB_W-1:0]]];
                for (x = 0; x < 16; x++)
                    nxt[x[NIB_W-1:0]] = cur[cur[x[NIB_W-1:0]]];
                for (x = 0; x < 16; x++)
                    cur[x[NIB_W-1:0]] = nxt[x[NIB_W-1:0]];
            end
            for (x = 0; x < 16; x++)
                kstep_tbl[{d[NIB_W-1:0], x[NIB_W-1:0]}] = acc[x[NIB_W-1:0]];
        end
        tbl_ready = 1'b1;
    endtask

    task automatic predict_pair(input in_item_t item, output out_item_t res);
        if (!tbl_ready)
            rebuild_kstep();
        res.potentials_out[3:0] = kstep_tbl[{item.drives_in[3:0], item.potentials_in[3:0]}];
        res.potentials_out[7:4] = kstep_tbl[{item.drives_in[7:4], item.potentials_in[7:4]}];
        res.last_out            = item.last_pair;
    endtask

    function automatic int pick_gap(bit burst);
        int r;
        if (burst)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    task automatic note_error(input string what, input out_item_t want, input out_item_t got);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("%0t %s: expected potentials=%h last=%b, actual potentials=%h last=%b",
                     $realtime, what, want.potentials_out, want.last_out,
                     got.potentials_out, got.last_out);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t res;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_pair(in_data, res);
                expected_pairs.push_back(res);
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pairs_to_send.size() > 0)
                begin
                    in_data  <= pairs_to_send.pop_front();
                    in_valid <= 1'b1;
                    send_gap = pick_gap(send_burst);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_pairs.size() == 0)
                    note_error("unexpected transaction", '0, out_data);
                else
                begin
                    want = expected_pairs.pop_front();
                    if (out_data.potentials_out !== want.potentials_out ||
                        out_data.last_out !== want.last_out)
                        note_error("mismatch", want, out_data);
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                stall_left = pick_gap(recv_burst);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (pairs_to_send.size() == 0 && !in_valid && expected_pairs.size() == 0))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired after %0d stalled cycles", idle_cycles);
            $display("DONE: errors detected");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == CFG_FIRE_THRESHOLD)
        begin
            thr_reg   = val[THR_W-1:0];
            tbl_ready = 1'b0;
        end
        else if (idx == CFG_STEP_COUNT)
        begin
            steps_reg = val[STEP_BITS-1:0];
            tbl_ready = 1'b0;
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] thr);
        logic [CFG_DATA_W-1:0] val;
        val = $urandom();
        val[THR_W-1:0] = thr;
        write_reg(CFG_FIRE_THRESHOLD, val);
    endtask

    task automatic queue_pair(input logic [7:0] pot, input logic [7:0] drv, input logic lst);
        in_item_t item;
        item.potentials_in = pot;
        item.drives_in     = drv;
        item.last_pair     = lst;
        pairs_to_send.push_back(item);
    endtask

    task automatic queue_directed();
        queue_pair(8'h00, 8'h00, 1'b0);
        queue_pair(8'hff, 8'hff, 1'b1);
        queue_pair(8'h0f, 8'hf0, 1'b0);
        queue_pair(8'hf0, 8'h0f, 1'b1);
        queue_pair(8'hff, 8'h00, 1'b0);
        queue_pair(8'h00, 8'hff, 1'b0);
        queue_pair(8'h87, 8'h78, 1'b0);
        queue_pair(8'h5a, 8'ha5, 1'b1);
    endtask

    // mostly whole arrays of pairs ending in a marked last pair, some stray pairs
    task automatic queue_random(input int n);
        int sent;
        int len;
        int k;
        sent = 0;
        while (sent < n)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                len = $urandom_range(1, 16);
                for (k = 0; k < len; k++)
                    queue_pair(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                               k == len - 1);
                sent += len;
            end
            else
            begin
                queue_pair(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           1'($urandom_range(0, 1)));
                sent++;
            end
        end
    endtask

    task automatic run_and_drain(input bit directed, input int n);
        @(negedge clk);
        send_burst = ($urandom_range(0, 3) == 0);
        recv_burst = ($urandom_range(0, 3) == 0);
        if (directed)
            queue_directed();
        queue_random(n);
        while (pairs_to_send.size() != 0 || in_valid || expected_pairs.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int p;
        errors      = 0;
        idle_cycles = 0;
        send_burst  = 1'b0;
        recv_burst  = 1'b0;
        thr_reg     = THR_RESET;
        steps_reg   = STEP_RESET;
        tbl_ready   = 1'b0;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        run_and_drain(1'b1, 150);

        // zero steps pass potentials through
        write_threshold(8'd0);
        write_reg(CFG_STEP_COUNT, 32'd0);
        run_and_drain(1'b1, 100);

        // zero threshold clears every neuron
        write_reg(CFG_STEP_COUNT, 32'd7);
        run_and_drain(1'b1, 100);

        write_threshold(8'd255);
        write_reg(CFG_STEP_COUNT, 32'hffff_ffff);
        run_and_drain(1'b0, 150);

        write_threshold(8'd15);
        write_reg(CFG_STEP_COUNT, 32'd1);
        run_and_drain(1'b0, 120);

        // writes to unused indexes leave the table alone
        write_reg(CFG_SPARE_A, $urandom());
        write_reg(CFG_SPARE_B, $urandom());
        run_and_drain(1'b0, 120);

        for (p = 0; p < 8; p++)
        begin
            write_threshold(THR_W'($urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                                                             : $urandom_range(0, 17)));
            case ($urandom_range(0, 2))
                0: write_reg(CFG_STEP_COUNT, $urandom_range(0, 40));
                1: write_reg(CFG_STEP_COUNT, $urandom());
                default: write_reg(CFG_STEP_COUNT, 32'h8000_0000 | $urandom_range(0, 3));
            endcase
            run_and_drain(1'b0, 135);
        end

        errors += expected_pairs.size();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
